@@ src/lcgt_pkg.sv @@
// ----------------------------------------------------------------------------
// lcgt_pkg: shared types and constants of the LCG seed index tracker
// Holds the generator constants, the jump-ahead tables for steps of 2^k,
// register indexes and the structs passed between the front and back parts.
// ----------------------------------------------------------------------------
package lcgt_pkg;

    typedef logic [31:0] word_t;
    typedef word_t jump_tab_t [32];

    // generator x' = x * LCG_MUL + LCG_ADD (mod 2^32), started from LCG_START
    localparam word_t LCG_MUL       = 32'h41C6_4E6D;
    localparam word_t LCG_ADD       = 32'h0000_3039;
    localparam word_t LCG_START     = 32'h5555_5555;
    localparam word_t SHOW_LIMIT    = 32'd99999;
    localparam word_t BURST_MIN_RST = 32'd600;
    localparam word_t BURST_MAX_RST = 32'd100000;

    // configuration register indexes
    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_BURST_MIN = 2'd1;
    localparam logic [1:0] REG_BURST_MAX = 2'd2;

    // multiplier of the map that advances the generator by 2^k steps
    function automatic jump_tab_t gen_jump_mul();
        jump_tab_t t;
        word_t     hm;
        hm = LCG_MUL;
        for (int j = 0; j < 32; j++) begin
            t[j] = hm;
            hm   = hm * hm;
        end
        return t;
    endfunction

    // increment of the map that advances the generator by 2^k steps
    function automatic jump_tab_t gen_jump_add();
        jump_tab_t t;
        word_t     hm;
        word_t     ha;
        hm = LCG_MUL;
        ha = LCG_ADD;
        for (int j = 0; j < 32; j++) begin
            t[j] = ha;
            ha   = ha * hm + ha;
            hm   = hm * hm;
        end
        return t;
    endfunction

    localparam jump_tab_t JUMP_MUL = gen_jump_mul();
    localparam jump_tab_t JUMP_ADD = gen_jump_add();

    // configuration as seen by the datapath
    typedef struct packed {
        logic  enable;
        word_t burst_min;
        word_t burst_max;
    } cfg_t;

    // classified word waiting in the queue
    typedef struct packed {
        word_t seed;
        logic  active;
    } qitem_t;

    // one result word
    typedef struct packed {
        logic  active;
        word_t seed_index;
        word_t step_delta;
        logic  delta_shown;
        word_t burst_seed;
        logic  burst_seed_valid;
    } res_t;

endpackage

@@ src/lcg_seed_index_tracker.sv @@
// ----------------------------------------------------------------------------
// lcg_seed_index_tracker: LCG step index and burst seed tracker
// Sequence: an active frame is popped from the queue, then the solver tests
//   each index bit in turn, with a multiply-add after each set index bit
//   below bit 31, then come the delta and output states. An inactive frame
//   goes straight from the pop to the output state.
// Flow: the back part pops the next frame only from idle; the queue takes
//   words meanwhile. A held result stalls the back part in its output state.
// Reset: synchronous active-low aresetn clears queue, tracking state and
//   configuration (tracking off, burst window 600..100000).
// ----------------------------------------------------------------------------
module lcg_seed_index_tracker #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed
    input  logic        s_tuser,   // [0] game_running
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [31:0] seed_index, [63:32] step_delta,
                                   // [95:64] burst_seed
    output logic [2:0]  m_tuser    // [0] active, [1] delta_shown,
                                   // [2] burst_seed_valid
);

    lcgt_pkg::cfg_t   cfg_reg, cfg_next;
    logic             clr_last;
    logic             q_full, q_push, q_not_empty, q_pop;
    lcgt_pkg::qitem_t push_item, head_item;
    lcgt_pkg::res_t   res;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        clr_last = 1'b0;
        if (cfg_we) begin
            unique case (cfg_index)
                lcgt_pkg::REG_ENABLE: begin
                    cfg_next.enable = cfg_wdata[0];
                    clr_last        = 1'b1;
                end
                lcgt_pkg::REG_BURST_MIN: cfg_next.burst_min = cfg_wdata;
                lcgt_pkg::REG_BURST_MAX: cfg_next.burst_max = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable    <= 1'b0;
            cfg_reg.burst_min <= lcgt_pkg::BURST_MIN_RST;
            cfg_reg.burst_max <= lcgt_pkg::BURST_MAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lcgt_front u_front (
        .enable    (cfg_reg.enable),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_seed    (s_tdata),
        .s_running (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    lcgt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    lcgt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .clr_last (clr_last),
        .q_valid  (q_not_empty),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (res)
    );

    // result packing
    assign m_tdata = {res.burst_seed, res.step_delta, res.seed_index};
    assign m_tuser = {res.burst_seed_valid, res.delta_shown, res.active};

    // inactive frames carry all-zero fields
    a_inactive_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0 && m_tuser[2:1] == 2'b00))
        else $error("inactive result with nonzero fields");

    // a shown delta is nonzero and within the display limit
    a_shown_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |->
        (m_tdata[63:32] != '0 && m_tdata[63:32] <= lcgt_pkg::SHOW_LIMIT))
        else $error("delta_shown outside its range");

    // burst seed stays zero until a burst has been latched
    a_burst_seed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[2]) |-> (m_tdata[95:64] == '0))
        else $error("burst seed nonzero without a latched burst");

endmodule

@@ src/lcgt_front.sv @@
// ----------------------------------------------------------------------------
// lcgt_front: input acceptance and frame classification
// Takes input words while the queue has room and marks each frame active
// when tracking is enabled and the sampled machine runs.
// ----------------------------------------------------------------------------
module lcgt_front (
    input  logic                  enable,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  lcgt_pkg::word_t       s_seed,
    input  logic                  s_running,
    input  logic                  q_full,
    output logic                  q_push,
    output lcgt_pkg::qitem_t      q_item
);

    // accept whenever the queue can take the word
    assign s_tready = ~q_full;
    assign q_push   = s_tvalid & ~q_full;

    // classify: inactive frames skip the solver in the back part
    assign q_item.seed   = s_seed;
    assign q_item.active = enable & s_running;

endmodule

@@ src/lcgt_queue.sv @@
// ----------------------------------------------------------------------------
// lcgt_queue: short FIFO between front and back
// Register-based circular buffer; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module lcgt_queue #(
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  lcgt_pkg::qitem_t push_item,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output lcgt_pkg::qitem_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcgt_pkg::qitem_t store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = store_reg[rd_ptr_reg];
    assign do_push   = push & ~full;
    assign do_pop    = pop & not_empty;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ src/lcgt_solver.sv @@
// ----------------------------------------------------------------------------
// lcgt_solver: bit-serial step index recovery
// Lifts the step count one bit per iteration. The generator state for the
// partial count is kept in a register and advanced by the 2^k jump map
// (one multiply-add) whenever a bit k below bit 31 is set.
// ----------------------------------------------------------------------------
module lcgt_solver (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  lcgt_pkg::word_t seed_in,
    output logic            done,
    output lcgt_pkg::word_t index
);

    typedef enum logic [2:0] {
        SV_IDLE = 3'b001,
        SV_CMP  = 3'b010,
        SV_MUL  = 3'b100
    } sv_state_t;

    sv_state_t       state_reg, state_next;
    logic [4:0]      k_reg, k_next;
    lcgt_pkg::word_t x_reg, x_next;
    lcgt_pkg::word_t n_reg, n_next;
    lcgt_pkg::word_t seed_reg, seed_next;
    logic            done_reg, done_next;
    lcgt_pkg::word_t mask;
    logic            mismatch;

    // low k+1 bits must agree with the sampled word
    assign mask     = 32'hFFFF_FFFF >> (5'd31 - k_reg);
    assign mismatch = |((x_reg ^ seed_reg) & mask);

    assign done  = done_reg;
    assign index = n_reg;

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        x_next     = x_reg;
        n_next     = n_reg;
        seed_next  = seed_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            SV_IDLE: begin
                if (start) begin
                    x_next     = lcgt_pkg::LCG_START;
                    n_next     = '0;
                    k_next     = '0;
                    seed_next  = seed_in;
                    state_next = SV_CMP;
                end
            end
            SV_CMP: begin
                if (mismatch) begin
                    n_next[k_reg] = 1'b1;
                end
                if (k_reg == 5'd31) begin
                    done_next  = 1'b1;
                    state_next = SV_IDLE;
                end else if (mismatch) begin
                    state_next = SV_MUL;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            SV_MUL: begin
                // advance the partial state by 2^k steps
                x_next     = x_reg * lcgt_pkg::JUMP_MUL[k_reg] + lcgt_pkg::JUMP_ADD[k_reg];
                k_next     = k_reg + 1'b1;
                state_next = SV_CMP;
            end
            default: state_next = SV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SV_IDLE;
            done_reg  <= 1'b0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        n_reg    <= n_next;
        seed_reg <= seed_next;
    end

endmodule

@@ src/lcgt_back.sv @@
// ----------------------------------------------------------------------------
// lcgt_back: frame execution and tracking state
// Pops classified words, runs the index solver for active frames, works out
// the step delta and burst latch, and holds the result in an output register.
// ----------------------------------------------------------------------------
module lcgt_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  lcgt_pkg::cfg_t   cfg,
    input  logic             clr_last,
    input  logic             q_valid,
    input  lcgt_pkg::qitem_t q_item,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output lcgt_pkg::res_t   m_res
);

    typedef enum logic [3:0] {
        BK_IDLE  = 4'b0001,
        BK_SOLVE = 4'b0010,
        BK_DELTA = 4'b0100,
        BK_OUT   = 4'b1000
    } bk_state_t;

    bk_state_t        state_reg, state_next;
    lcgt_pkg::qitem_t item_reg, item_next;
    lcgt_pkg::word_t  idx_reg, idx_next;
    lcgt_pkg::word_t  delta_reg, delta_next;
    lcgt_pkg::word_t  last_index_reg, last_index_next;
    lcgt_pkg::word_t  last_seed_reg, last_seed_next;
    logic             last_valid_reg, last_valid_next;
    lcgt_pkg::word_t  latched_seed_reg, latched_seed_next;
    logic             latched_valid_reg, latched_valid_next;
    lcgt_pkg::res_t   out_reg, out_next;
    logic             m_valid_reg, m_valid_next;
    logic             solve_start, solve_done;
    lcgt_pkg::word_t  solve_index;
    logic             out_free, in_window, show_ok;

    assign q_pop       = (state_reg == BK_IDLE) && q_valid;
    assign solve_start = q_pop && q_item.active;
    assign out_free    = ~m_valid_reg | m_ready;
    assign m_valid     = m_valid_reg;
    assign m_res       = out_reg;

    lcgt_solver u_solver (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (solve_start),
        .seed_in (q_item.seed),
        .done    (solve_done),
        .index   (solve_index)
    );

    // burst window and display test on the registered delta
    assign in_window = last_valid_reg && (delta_reg >= cfg.burst_min)
                       && (delta_reg <= cfg.burst_max);
    assign show_ok   = last_valid_reg && (delta_reg != '0)
                       && (delta_reg <= lcgt_pkg::SHOW_LIMIT);

    always_comb begin
        state_next         = state_reg;
        item_next          = item_reg;
        idx_next           = idx_reg;
        delta_next         = delta_reg;
        last_index_next    = last_index_reg;
        last_seed_next     = last_seed_reg;
        last_valid_next    = last_valid_reg;
        latched_seed_next  = latched_seed_reg;
        latched_valid_next = latched_valid_reg;
        out_next           = out_reg;
        m_valid_next       = m_valid_reg & ~m_ready;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    item_next  = q_item;
                    state_next = q_item.active ? BK_SOLVE : BK_OUT;
                end
            end
            BK_SOLVE: begin
                if (solve_done) begin
                    idx_next   = solve_index;
                    state_next = BK_DELTA;
                end
            end
            BK_DELTA: begin
                delta_next = last_valid_reg ? (idx_reg - last_index_reg) : '0;
                state_next = BK_OUT;
            end
            BK_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (item_reg.active) begin
                        if (in_window) begin
                            latched_seed_next  = last_seed_reg;
                            latched_valid_next = 1'b1;
                        end
                        last_index_next      = idx_reg;
                        last_seed_next       = item_reg.seed;
                        last_valid_next      = 1'b1;
                        out_next.active      = 1'b1;
                        out_next.seed_index  = idx_reg;
                        out_next.step_delta  = delta_reg;
                        out_next.delta_shown = show_ok;
                        out_next.burst_seed  = in_window ? last_seed_reg : latched_seed_reg;
                        out_next.burst_seed_valid = in_window | latched_valid_reg;
                    end else begin
                        last_valid_next = 1'b0;
                        out_next        = '0;
                    end
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
        // enable write drops the previous-frame mark
        if (clr_last) begin
            last_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= BK_IDLE;
            m_valid_reg       <= 1'b0;
            last_index_reg    <= '0;
            last_seed_reg     <= '0;
            last_valid_reg    <= 1'b0;
            latched_seed_reg  <= '0;
            latched_valid_reg <= 1'b0;
        end else begin
            state_reg         <= state_next;
            m_valid_reg       <= m_valid_next;
            last_index_reg    <= last_index_next;
            last_seed_reg     <= last_seed_next;
            last_valid_reg    <= last_valid_next;
            latched_seed_reg  <= latched_seed_next;
            latched_valid_reg <= latched_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        idx_reg   <= idx_next;
        delta_reg <= delta_next;
        out_reg   <= out_next;
    end

endmodule
